### sv/expected_flow_table_top_macros.svh
// ----------------------------------------------------------------------------
// Expected flow table assertion macros
// Clocked, reset-qualified assertion forms used by the flow table top.
// ----------------------------------------------------------------------------
`ifndef EXPECTED_FLOW_TABLE_TOP_MACROS_SVH
`define EXPECTED_FLOW_TABLE_TOP_MACROS_SVH

// Check a property at every clock edge outside reset.
`define EFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies a result in the next.
`define EFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/eft_pkg.sv
// ----------------------------------------------------------------------------
// Expected flow table package
// Table depth, operation and status codes, and the types shared by the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package eft_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENTRIES_W   = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_HIT      = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // One stored flow
  typedef struct packed {
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    logic [7:0]  protocol;
    logic [15:0] port;
  } entry_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic        exec;
    op_e         op;
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    logic [7:0]  protocol;
    logic [15:0] port_a;
    logic [15:0] port_b;
  } cell_cmd_t;

endpackage

`default_nettype wire

### sv/expected_flow_table_top.sv
// ----------------------------------------------------------------------------
// Expected flow table
// Insertion-ordered table of expected flows held in a row of cells, with
// insert, direction-blind search, and delete of the first match.
//
//   channel  dir  tuser            tdata
//   s_axis   in   opcode           addr_a, addr_b, protocol, port_a, port_b
//   m_axis   out  status           entries_held
//
// Each request is registered, then compared, run through the first-match
// chain and shifted across the whole cell row in its execute state. A new
// request is taken only once the previous one has committed.
// Reset empties the table at once through the cell valid bits.
// A result held by a stalled m_axis keeps the next request waiting in its
// execute cycle; a new request is still taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module expected_flow_table_top
  import eft_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] addr_a, [63:32] addr_b, [71:64] protocol, [87:72] port_a,
  // [103:88] port_b
  input  wire logic [103:0] s_axis_tdata,
  // [1:0] opcode
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [4:0] entries_held, [7:5] zero
  output logic [7:0]        m_axis_tdata,
  // [1:0] status
  output logic [1:0]        m_axis_tuser
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e     state_q;
  cell_cmd_t  cmd_q, cmd;
  logic       commit;
  logic [CNT_W-1:0] occ_q, occ_d;
  status_e    status_d, status_q;
  logic       m_valid_q;
  logic       full, any_hit;
  logic       ins_grow, del_hit;

  entry_t                 cell_entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_valid;
  logic [TABLE_DEPTH:0]   seen;

  assign s_axis_tready = (state_q == S_IDLE);
  assign commit        = (state_q == S_EXEC) && (!m_valid_q || m_axis_tready);

  always_comb begin
    cmd      = cmd_q;
    cmd.exec = commit;
  end

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic   prev_valid, next_valid;
    entry_t next_entry;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = cell_valid[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign next_entry = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_entry = cell_entry[i+1];
      assign next_valid = cell_valid[i+1];
    end

    eft_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_valid_i (prev_valid),
      .next_entry_i (next_entry),
      .next_valid_i (next_valid),
      .seen_i       (seen[i]),
      .seen_o       (seen[i+1]),
      .entry_o      (cell_entry[i]),
      .valid_o      (cell_valid[i])
    );
  end

  assign full    = cell_valid[TABLE_DEPTH-1];
  assign any_hit = seen[TABLE_DEPTH];

  always_comb begin
    occ_d    = occ_q;
    status_d = ST_NONE;
    case (cmd_q.op)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          occ_d    = occ_q + 1'b1;
        end
      end
      OP_SEARCH: begin
        if (any_hit) status_d = ST_HIT;
      end
      OP_DELETE: begin
        if (any_hit) begin
          status_d = ST_HIT;
          occ_d    = occ_q - 1'b1;
        end
      end
      default: begin
        status_d = ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      occ_q     <= '0;
      m_valid_q <= 1'b0;
      status_q  <= ST_NONE;
    end else begin
      case (state_q)
        S_IDLE: begin
          // Drop the result once taken
          if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
          if (s_axis_tvalid) state_q <= S_EXEC;
        end
        S_EXEC: begin
          // A commit replaces any result taken at this edge
          if (commit) begin
            state_q   <= S_IDLE;
            occ_q     <= occ_d;
            status_q  <= status_d;
            m_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the request for its execute cycle
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q.exec     <= 1'b0;
      cmd_q.op       <= op_e'(s_axis_tuser);
      cmd_q.addr_a   <= s_axis_tdata[31:0];
      cmd_q.addr_b   <= s_axis_tdata[63:32];
      cmd_q.protocol <= s_axis_tdata[71:64];
      cmd_q.port_a   <= s_axis_tdata[87:72];
      cmd_q.port_b   <= s_axis_tdata[103:88];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {3'b000, ENTRIES_W'(occ_q)};

  assign ins_grow = commit && (cmd_q.op == OP_INSERT) && !full;
  assign del_hit  = commit && (cmd_q.op == OP_DELETE) && any_hit;

  `include "expected_flow_table_top_macros.svh"

  `EFT_ASSERT(a_count_matches_cells, $countones(cell_valid) == occ_q, "count disagrees")
  `EFT_ASSERT(a_valid_packed, (cell_valid & (cell_valid + 1'b1)) == '0, "cells not packed")
  `EFT_ASSERT_NEXT(a_insert_grows, ins_grow, occ_q == $past(occ_q) + 1'b1, "insert no growth")
  `EFT_ASSERT_NEXT(a_delete_frees_top, del_hit, !cell_valid[TABLE_DEPTH-1], "top cell valid")

endmodule

`default_nettype wire

### sv/eft_cell.sv
// ----------------------------------------------------------------------------
// Expected flow table cell
// Holds one flow and its valid bit, matches it against the broadcast
// operation, and takes its upper neighbor's flow when a delete closes a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module eft_cell
  import eft_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_cmd_t cmd_i,
  input  wire logic      prev_valid_i,
  input  wire entry_t    next_entry_i,
  input  wire logic      next_valid_i,
  input  wire logic      seen_i,
  output logic           seen_o,
  output entry_t         entry_o,
  output logic           valid_o
);

  entry_t entry_q, entry_d;
  logic   valid_q, valid_d;
  logic   match, hit, do_ins, do_shift;

  always_comb begin
    match = ((entry_q.addr_a == cmd_i.addr_a) || (entry_q.addr_a == cmd_i.addr_b)) &&
            ((entry_q.addr_b == cmd_i.addr_a) || (entry_q.addr_b == cmd_i.addr_b)) &&
            (entry_q.protocol == cmd_i.protocol) &&
            ((entry_q.port == cmd_i.port_a) || (entry_q.port == cmd_i.port_b));
    hit    = valid_q && match;
    seen_o = seen_i || hit;

    // The first free cell sits right above the last valid one
    do_ins   = cmd_i.exec && (cmd_i.op == OP_INSERT) && !valid_q && prev_valid_i;
    // Every cell from the first match upward moves down by one
    do_shift = cmd_i.exec && (cmd_i.op == OP_DELETE) && seen_o;

    entry_d = entry_q;
    valid_d = valid_q;
    if (do_ins) begin
      entry_d.addr_a   = cmd_i.addr_a;
      entry_d.addr_b   = cmd_i.addr_b;
      entry_d.protocol = cmd_i.protocol;
      entry_d.port     = cmd_i.port_a;
      valid_d          = 1'b1;
    end else if (do_shift) begin
      entry_d = next_entry_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

### tb/sv/eft_flow_checker.sv
// ----------------------------------------------------------------------------
// Expected flow table checker
// Watches both stream channels of the flow table. It mirrors the table on
// every accepted request and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module eft_flow_checker
  import eft_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  input  wire logic         s_tready_i,
  // [31:0] addr_a, [63:32] addr_b, [71:64] protocol, [87:72] port_a,
  // [103:88] port_b
  input  wire logic [103:0] s_tdata_i,
  // [1:0] opcode
  input  wire logic [1:0]   s_tuser_i,
  input  wire logic         m_tvalid_i,
  input  wire logic         m_tready_i,
  // [4:0] entries_held, [7:5] zero
  input  wire logic [7:0]   m_tdata_i,
  // [1:0] status
  input  wire logic [1:0]   m_tuser_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                hits_o,
  output int                drops_o
);

  typedef struct {
    status_e    status;
    logic [4:0] held;
  } flow_result_t;

  // Mirror of the table, oldest flow at index 0
  logic [31:0] first_addr_mem  [TABLE_DEPTH];
  logic [31:0] second_addr_mem [TABLE_DEPTH];
  logic [7:0]  proto_mem       [TABLE_DEPTH];
  logic [15:0] port_mem        [TABLE_DEPTH];
  int          held_cnt;

  flow_result_t result_q[$];

  // Index of the earliest flow matching in either direction, or -1
  function automatic int first_flow_match(logic [31:0] a, logic [31:0] b,
                                          logic [7:0] proto,
                                          logic [15:0] pa, logic [15:0] pb);
    for (int i = 0; i < held_cnt; i++) begin
      if ((first_addr_mem[i] == a || first_addr_mem[i] == b) &&
          (second_addr_mem[i] == a || second_addr_mem[i] == b) &&
          proto_mem[i] == proto &&
          (port_mem[i] == pa || port_mem[i] == pb)) begin
        return i;
      end
    end
    return -1;
  endfunction

  always @(posedge clk_i) begin : track
    flow_result_t got;
    flow_result_t want;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [7:0]   proto;
    logic [15:0]  pa;
    logic [15:0]  pb;
    int           idx;
    if (!rst_ni) begin
      held_cnt = 0;
      result_q.delete();
      fail_count_o = 0;
      hits_o = 0;
      drops_o = 0;
      pending_o <= 0;
    end else begin
      // Retire the result first: it belongs to an earlier request
      if (m_tvalid_i && m_tready_i) begin
        if (result_q.size() == 0) begin
          $error("result with no request outstanding: status %0d entries_held %0d",
                 m_tuser_i, m_tdata_i[4:0]);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          if (m_tuser_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser_i);
            fail_count_o++;
          end
          if (m_tdata_i[4:0] !== want.held) begin
            $error("entries_held: expected %0d, got %0d", want.held, m_tdata_i[4:0]);
            fail_count_o++;
          end
          if (m_tdata_i[7:5] !== 3'b000) begin
            $error("tdata pad: expected 0, got %0d", m_tdata_i[7:5]);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        a     = s_tdata_i[31:0];
        b     = s_tdata_i[63:32];
        proto = s_tdata_i[71:64];
        pa    = s_tdata_i[87:72];
        pb    = s_tdata_i[103:88];
        got.status = ST_NONE;
        case (s_tuser_i)
          OP_INSERT: begin
            if (held_cnt >= TABLE_DEPTH) begin
              got.status = ST_FULL;
              drops_o++;
            end else begin
              first_addr_mem[held_cnt]  = a;
              second_addr_mem[held_cnt] = b;
              proto_mem[held_cnt]       = proto;
              port_mem[held_cnt]        = pa;
              held_cnt++;
              got.status = ST_INSERTED;
            end
          end
          OP_SEARCH: begin
            if (first_flow_match(a, b, proto, pa, pb) >= 0) begin
              got.status = ST_HIT;
              hits_o++;
            end
          end
          OP_DELETE: begin
            idx = first_flow_match(a, b, proto, pa, pb);
            if (idx >= 0) begin
              // Close the gap, keeping insertion order
              for (int j = idx; j < held_cnt - 1; j++) begin
                first_addr_mem[j]  = first_addr_mem[j + 1];
                second_addr_mem[j] = second_addr_mem[j + 1];
                proto_mem[j]       = proto_mem[j + 1];
                port_mem[j]        = port_mem[j + 1];
              end
              held_cnt--;
              got.status = ST_HIT;
              hits_o++;
            end
          end
          default: ;
        endcase
        got.held = held_cnt[4:0];
        result_q.push_back(got);
      end
      pending_o <= result_q.size();
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Expected flow table testbench
// Drives directed and random table operations through the request stream
// under several idle and stall mixes; a checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import eft_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         PHASE_ITEMS  = 350;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         POOL_DEPTH   = 24;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = OP_INSERT;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  int fail_count;
  int pending;
  int hit_count;
  int drop_count;
  int sent_count = 0;
  int cycle_cnt = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  entry_t      flow_pool[$];
  logic [31:0] addr_set[6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001,
                               32'h0A00_0002, 32'hC0A8_0101, 32'h8000_0000};
  logic [7:0]  proto_set[4] = '{8'd6, 8'd17, 8'd0, 8'd255};

  expected_flow_table_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  eft_flow_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .hits_o       (hit_count),
    .drops_o      (drop_count)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Hold the request until the block takes it; leave tvalid high afterwards
  task automatic send_request(input logic [1:0] op, input logic [31:0] a,
                              input logic [31:0] b, input logic [7:0] proto,
                              input logic [15:0] pa, input logic [15:0] pb);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {pb, pa, proto, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(9) < 6) return addr_set[$urandom_range(5)];
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_proto();
    if ($urandom_range(3) != 0) return proto_set[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] pick_port();
    if ($urandom_range(1) != 0) return 16'($urandom_range(3));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic random_request(input bit fill_bias);
    int          roll;
    logic [1:0]  op;
    entry_t      f;
    logic [31:0] a;
    logic [31:0] b;
    logic [7:0]  proto;
    logic [15:0] pa;
    logic [15:0] pb;
    roll = $urandom_range(99);
    if (fill_bias) begin
      op = (roll < 55) ? OP_INSERT : (roll < 75) ? OP_SEARCH :
           (roll < 97) ? OP_DELETE : OP_UNUSED;
    end else begin
      op = (roll < 25) ? OP_INSERT : (roll < 50) ? OP_SEARCH :
           (roll < 96) ? OP_DELETE : OP_UNUSED;
    end
    if (op == OP_INSERT) begin
      if (flow_pool.size() != 0 && $urandom_range(3) == 0) begin
        f = flow_pool[$urandom_range(flow_pool.size() - 1)];
      end else begin
        f.addr_a   = pick_addr();
        f.addr_b   = pick_addr();
        f.protocol = pick_proto();
        f.port     = pick_port();
      end
      flow_pool.push_back(f);
      if (flow_pool.size() > POOL_DEPTH) void'(flow_pool.pop_front());
      send_request(op, f.addr_a, f.addr_b, f.protocol, f.port,
                   16'($urandom_range(16'hFFFF)));
    end else if (op != OP_UNUSED && flow_pool.size() != 0 && $urandom_range(9) < 7) begin
      // Look up a known flow, in either direction and on either port slot
      f = flow_pool[$urandom_range(flow_pool.size() - 1)];
      if ($urandom_range(1) != 0) begin
        a = f.addr_a;
        b = f.addr_b;
      end else begin
        a = f.addr_b;
        b = f.addr_a;
      end
      proto = f.protocol;
      if ($urandom_range(1) != 0) begin
        pa = f.port;
        pb = pick_port();
      end else begin
        pa = pick_port();
        pb = f.port;
      end
      // Break one field now and then for near misses
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(3))
          0: a = a ^ (32'h1 << $urandom_range(31));
          1: proto = proto + 8'd1;
          2: begin
            pa = f.port ^ 16'h0100;
            pb = f.port ^ 16'h8000;
          end
          default: b = pick_addr();
        endcase
      end
      send_request(op, a, b, proto, pa, pb);
    end else begin
      send_request(op, pick_addr(), pick_addr(), pick_proto(), pick_port(), pick_port());
    end
  endtask

  initial begin
    int sender_pct[4];
    int receiver_pct[4];
    sender_pct   = '{0, 61, 0, 13};
    receiver_pct = '{0, 0, 61, 13};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extremes, both directions, duplicates, full table
    send_request(OP_SEARCH, 32'h0, 32'h0, 8'd0, 16'h0, 16'h0);
    send_request(OP_DELETE, 32'hFFFF_FFFF, 32'h0, 8'd255, 16'hFFFF, 16'h0);
    send_request(OP_UNUSED, 32'h0, 32'h0, 8'd0, 16'h0, 16'h0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 8'd255, 16'hFFFF, 16'h0);
    send_request(OP_INSERT, 32'h0, 32'h0, 8'd0, 16'h0, 16'hFFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 8'd255, 16'hFFFF, 16'hFFFF);
    send_request(OP_SEARCH, 32'h0, 32'hFFFF_FFFF, 8'd255, 16'h0001, 16'hFFFF);
    send_request(OP_DELETE, 32'hFFFF_FFFF, 32'h0, 8'd255, 16'hFFFF, 16'h0);
    send_request(OP_DELETE, 32'hFFFF_FFFF, 32'h0, 8'd254, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < TABLE_DEPTH - 2; i++) begin
      send_request(OP_INSERT, 32'h0A00_0000 + i, 32'hC0A8_0000 + i, 8'd6,
                   16'(16'd1000 + i), 16'h0);
    end
    send_request(OP_INSERT, 32'h1234_5678, 32'h8765_4321, 8'd17, 16'h5555, 16'hAAAA);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 16'hFFFF, 16'hFFFF);
    wait_results_done();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = sender_pct[phase];
      stall_pct = receiver_pct[phase];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Swing between filling and draining the table every 50 requests
        random_request(((i / 50) % 2) == 0);
      end
      wait_results_done();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("tb: %0d requests over four idle/stall mixes; %0d search/delete hits,",
             sent_count, hit_count);
    $display("tb: %0d inserts dropped on a full table, directed extremes included",
             drop_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
